@@ rtl/core/tcsf_pkg.sv @@
// ----------------------------------------------------------------------------
// tcsf_pkg
// Shared types and codes for the threshold crossing sample filter: the
// opcode, threshold kind and reason codes, and the structs that travel
// along the chain of rule cells.
// ----------------------------------------------------------------------------
package tcsf_pkg;

  // width of the resource key: object, instance, resource from high to low
  localparam int unsigned KeyBits  = 48;
  localparam int unsigned SlotBits = 2;

  typedef enum logic [1:0] {
    OP_SAMPLE    = 2'd0,
    OP_WRITE_KEY = 2'd1,
    OP_WRITE_THR = 2'd2,
    OP_NOP       = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_GT   = 2'd0,
    KIND_LT   = 2'd1,
    KIND_ST   = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    REASON_ACK       = 4'd0,
    REASON_NO_ENTRY  = 4'd1,
    REASON_NO_THR    = 4'd2,
    REASON_GT_CROSS  = 4'd3,
    REASON_LT_CROSS  = 4'd4,
    REASON_ST_FIRST  = 4'd5,
    REASON_STEP      = 4'd6,
    REASON_ABOVE     = 4'd7,
    REASON_BELOW     = 4'd8,
    REASON_STEP_SMALL = 4'd9,
    REASON_NONE      = 4'd10
  } reason_e;

  // command fields of one input transaction, minus the sample value
  typedef struct packed {
    opcode_e               opcode;
    logic [SlotBits-1:0]   slot;
    logic [KeyBits-1:0]    key;
    logic                  key_en;
    kind_e                 kind;
    logic                  thr_en;
  } item_t;

  // result carried along the chain; done marks a result already settled
  typedef struct packed {
    logic                  done;
    logic                  keep;
    reason_e               reason;
    logic                  matched;
    logic [SlotBits-1:0]   slot;
  } result_t;

endpackage

@@ rtl/core/threshold_crossing_sample_filter_top.sv @@
// ----------------------------------------------------------------------------
// threshold_crossing_sample_filter_top
// Resource-keyed sample filter: a chain of rule cells, one per slot, that
// keeps samples crossing gt/lt, stepping by st or more, or with no threshold.
// ----------------------------------------------------------------------------
//  channel   direction  tuser     tdata (lowest bit first)
//  s_axis    in         opcode    entry_slot, object_id, instance_id,
//                                 resource_id, key_enable, threshold_kind,
//                                 threshold_enable, value_fixed, zero pad
//  m_axis    out        -         keep, reason, matched, matched_slot
//
//  a transaction enters cell 0 and moves one cell per cycle while the chain
//  advances; the result leaves from the last cell's register
//  one transaction per cycle is sustained while not stalled, each cell
//  updating its slot as it passes, so later transactions see earlier updates
//  a stalled output freezes the whole chain; s_axis_tready follows it
//  reset empties all slots, switches thresholds off and clears history
// ----------------------------------------------------------------------------
module threshold_crossing_sample_filter_top #(
  parameter int ENTRIES     = 4,
  parameter int SAMPLE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // entry_slot[1:0], object_id[17:2], instance_id[33:18], resource_id[49:34],
  // key_enable[50], threshold_kind[52:51], threshold_enable[53],
  // value_fixed[85:54], zero[87:86]
  input  logic [87:0] s_axis_tdata_i,
  // opcode[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // keep[0], reason[4:1], matched[5], matched_slot[7:6]
  output logic [7:0]  m_axis_tdata_o
);
  import tcsf_pkg::*;

  localparam int WideBits = ((SAMPLE_BITS > 32) ? SAMPLE_BITS : 32) + 1;
  localparam logic signed [WideBits-1:0] SatHi =
    WideBits'((65'sd1 <<< (SAMPLE_BITS - 1)) - 65'sd1);
  localparam logic signed [WideBits-1:0] SatLo = -SatHi - WideBits'(1);

  logic                          advance;
  logic                          valid_s  [ENTRIES+1];
  item_t                         item_s   [ENTRIES+1];
  logic signed [SAMPLE_BITS-1:0] value_s  [ENTRIES+1];
  result_t                       result_s [ENTRIES+1];
  logic signed [WideBits-1:0]    value_wide;
  item_t                         item_in;
  logic signed [SAMPLE_BITS-1:0] value_in;
  result_t                       result_in;
  result_t                       result_out;

  // chain moves whenever the output register is free or being drained
  assign advance         = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = advance;

  // unpack the incoming transaction
  always_comb begin
    item_in.opcode = opcode_e'(s_axis_tuser_i);
    item_in.slot   = s_axis_tdata_i[1:0];
    item_in.key    = {s_axis_tdata_i[17:2], s_axis_tdata_i[33:18], s_axis_tdata_i[49:34]};
    item_in.key_en = s_axis_tdata_i[50];
    item_in.kind   = kind_e'(s_axis_tdata_i[52:51]);
    item_in.thr_en = s_axis_tdata_i[53];
  end

  // sign-extend the Q16.16 value and saturate to the sample width
  always_comb begin
    value_wide = WideBits'($signed(s_axis_tdata_i[85:54]));
    if (value_wide > SatHi) begin
      value_wide = SatHi;
    end else if (value_wide < SatLo) begin
      value_wide = SatLo;
    end
    value_in = value_wide[SAMPLE_BITS-1:0];
  end

  // writes and the unused opcode are acknowledged at once; samples start out unmatched
  always_comb begin
    result_in.done    = (item_in.opcode != OP_SAMPLE);
    result_in.keep    = 1'b0;
    result_in.reason  = (item_in.opcode != OP_SAMPLE) ? REASON_ACK : REASON_NO_ENTRY;
    result_in.matched = 1'b0;
    result_in.slot    = '0;
  end

  // head of the chain
  assign valid_s[0]  = s_axis_tvalid_i;
  assign item_s[0]   = item_in;
  assign value_s[0]  = value_in;
  assign result_s[0] = result_in;

  // chain of rule cells, lowest slot first
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    tcsf_cell #(
      .Idx        (g),
      .SampleBits (SAMPLE_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .valid_i   (valid_s[g]),
      .item_i    (item_s[g]),
      .value_i   (value_s[g]),
      .result_i  (result_s[g]),
      .valid_o   (valid_s[g+1]),
      .item_o    (item_s[g+1]),
      .value_o   (value_s[g+1]),
      .result_o  (result_s[g+1])
    );
  end

  // the last cell's register is the output register
  assign result_out      = result_s[ENTRIES];
  assign m_axis_tvalid_o = valid_s[ENTRIES];
  assign m_axis_tdata_o  = {result_out.slot, result_out.matched, result_out.reason,
                            result_out.keep};

`ifndef SYNTHESIS
  // a write or unknown opcode never keeps or matches
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (result_out.reason == REASON_ACK))
      |-> (!result_out.keep && !result_out.matched))
    else $error("write acknowledge carries keep or match");

  // an unmatched result reports slot zero and is dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !result_out.matched)
      |-> ((result_out.slot == '0) && !result_out.keep))
    else $error("unmatched result with slot or keep set");

  // a kept sample always names a keeping reason
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && result_out.keep)
      |-> ((result_out.reason == REASON_NO_THR) || (result_out.reason == REASON_GT_CROSS) ||
           (result_out.reason == REASON_LT_CROSS) || (result_out.reason == REASON_ST_FIRST) ||
           (result_out.reason == REASON_STEP)))
    else $error("kept sample with a drop reason");

  // each result leaving the chain is settled by a cell or at entry, or reports no entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (result_out.done || (result_out.reason == REASON_NO_ENTRY)))
    else $error("unsettled result other than no entry");
`endif

endmodule

@@ rtl/core/tcsf_cell.sv @@
// ----------------------------------------------------------------------------
// tcsf_cell
// One rule slot of the filter chain. Holds the slot key, thresholds and
// sample history, applies writes aimed at its slot, claims the first
// unsettled sample whose key it matches, and registers the transaction
// on to the next cell.
// ----------------------------------------------------------------------------
module tcsf_cell #(
  parameter int Idx        = 0,
  parameter int SampleBits = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          advance_i,
  input  logic                          valid_i,
  input  tcsf_pkg::item_t               item_i,
  input  logic signed [SampleBits-1:0]  value_i,
  input  tcsf_pkg::result_t             result_i,
  output logic                          valid_o,
  output tcsf_pkg::item_t               item_o,
  output logic signed [SampleBits-1:0]  value_o,
  output tcsf_pkg::result_t             result_o
);
  import tcsf_pkg::*;

  // slot state
  logic [KeyBits-1:0]           key_q;
  logic                         used_q;
  logic signed [SampleBits-1:0] level_q [3];
  logic [2:0]                   on_q;
  logic signed [SampleBits-1:0] prev_q;
  logic                         prev_valid_q;
  logic signed [SampleBits-1:0] kept_q;
  logic                         kept_valid_q;

  // stage register toward the next cell
  logic                         valid_q;
  item_t                        item_q;
  logic signed [SampleBits-1:0] value_q;
  result_t                      result_q;

  logic                         slot_sel;
  logic                         hit;
  logic                         any_on;
  logic                         trigger;
  logic                         drop_set;
  reason_e                      reason;
  logic signed [SampleBits:0]   diff;
  logic [SampleBits:0]          mag;
  logic                         step_ok;
  result_t                      result_d;

  // slot select and sample match
  always_comb begin
    slot_sel = valid_i && (32'(item_i.slot) == 32'(Idx));
    hit      = valid_i && (item_i.opcode == OP_SAMPLE) && !result_i.done &&
               used_q && (key_q == item_i.key);
    any_on   = |on_q;
  end

  // distance from the last kept sample, one bit wider so it never wraps
  always_comb begin
    diff    = {value_i[SampleBits-1], value_i} - {kept_q[SampleBits-1], kept_q};
    mag     = diff[SampleBits] ? (SampleBits+1)'(0) - diff : diff;
    step_ok = $signed({1'b0, mag}) >=
              $signed({{2{level_q[KIND_ST][SampleBits-1]}}, level_q[KIND_ST]});
  end

  // crossing and step rules; the first drop reason in gt, lt, st order wins
  always_comb begin
    trigger  = 1'b0;
    drop_set = 1'b0;
    reason   = REASON_NONE;
    if (on_q[KIND_GT] && (value_i > level_q[KIND_GT])) begin
      if (!prev_valid_q || (prev_q <= level_q[KIND_GT])) begin
        trigger = 1'b1;
        reason  = REASON_GT_CROSS;
      end else begin
        drop_set = 1'b1;
        reason   = REASON_ABOVE;
      end
    end
    if (!trigger && on_q[KIND_LT] && (value_i < level_q[KIND_LT])) begin
      if (!prev_valid_q || (prev_q >= level_q[KIND_LT])) begin
        trigger = 1'b1;
        reason  = REASON_LT_CROSS;
      end else if (!drop_set) begin
        drop_set = 1'b1;
        reason   = REASON_BELOW;
      end
    end
    if (!trigger && on_q[KIND_ST]) begin
      if (!kept_valid_q) begin
        trigger = 1'b1;
        reason  = REASON_ST_FIRST;
      end else if (step_ok) begin
        trigger = 1'b1;
        reason  = REASON_STEP;
      end else if (!drop_set) begin
        drop_set = 1'b1;
        reason   = REASON_STEP_SMALL;
      end
    end
  end

  // settle the result when this slot claims the sample
  always_comb begin
    result_d = result_i;
    if (hit) begin
      result_d.done    = 1'b1;
      result_d.matched = 1'b1;
      result_d.slot    = SlotBits'(Idx);
      if (!any_on) begin
        result_d.keep   = 1'b1;
        result_d.reason = REASON_NO_THR;
      end else begin
        result_d.keep   = trigger;
        result_d.reason = reason;
      end
    end
  end

  // slot state updates from writes and claimed samples
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q        <= '0;
      used_q       <= 1'b0;
      level_q      <= '{default: '0};
      on_q         <= '0;
      prev_q       <= '0;
      prev_valid_q <= 1'b0;
      kept_q       <= '0;
      kept_valid_q <= 1'b0;
    end else if (advance_i) begin
      if (slot_sel && (item_i.opcode == OP_WRITE_KEY)) begin
        if (item_i.key_en) begin
          if (key_q != item_i.key) begin
            prev_valid_q <= 1'b0;
            kept_valid_q <= 1'b0;
          end
          key_q  <= item_i.key;
          used_q <= 1'b1;
        end else begin
          used_q <= 1'b0;
        end
      end
      if (slot_sel && (item_i.opcode == OP_WRITE_THR) && (item_i.kind != KIND_NONE)) begin
        for (int k = 0; k < 3; k++) begin
          if (item_i.kind == kind_e'(k)) begin
            if (item_i.thr_en) begin
              level_q[k] <= value_i;
              on_q[k]    <= 1'b1;
            end else begin
              on_q[k]      <= 1'b0;
              prev_valid_q <= 1'b0;
              kept_valid_q <= 1'b0;
            end
          end
        end
      end
      if (hit && any_on) begin
        prev_q       <= value_i;
        prev_valid_q <= 1'b1;
        if (trigger) begin
          kept_q       <= value_i;
          kept_valid_q <= 1'b1;
        end
      end
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      item_q   <= item_i;
      value_q  <= value_i;
      result_q <= result_d;
    end
  end

  assign valid_o  = valid_q;
  assign item_o   = item_q;
  assign value_o  = value_q;
  assign result_o = result_q;

endmodule

@@ tb/tb_threshold_crossing_sample_filter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_threshold_crossing_sample_filter_top
// Self-checking bench for the threshold crossing sample filter. Commands and
// samples go in over the input stream, and a local copy of the rule table
// predicts keep, reason and matched slot for every transaction. A short
// directed pass covers table writes, crossings and step rules. Random traffic
// on a small key pool follows, under three sender/receiver stall profiles.
// ----------------------------------------------------------------------------
module tb_threshold_crossing_sample_filter_top;
  import tcsf_pkg::*;

  localparam int ENTRIES     = 4;
  localparam int SAMPLE_BITS = 32;

  // result bits as they sit in m_axis_tdata: keep lowest, slot highest
  typedef struct packed {
    logic [1:0] slot;
    logic       matched;
    reason_e    reason;
    logic       keep;
  } filter_out_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [87:0] s_data  = '0;
  logic [1:0]  s_user  = '0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [7:0]  m_axis_tdata_o;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent_count    = 0;
  int checked_count = 0;
  int kept_count    = 0;
  int fail_count    = 0;

  filter_out_t expected_results[$];

  // local copy of the rule table and per-slot history
  logic [47:0]        rule_key   [ENTRIES]   = '{default: '0};
  logic               rule_used  [ENTRIES]   = '{default: 1'b0};
  logic signed [31:0] level      [ENTRIES*3] = '{default: '0};
  logic               level_on   [ENTRIES*3] = '{default: 1'b0};
  logic signed [31:0] seen_value [ENTRIES]   = '{default: '0};
  logic               seen_valid [ENTRIES]   = '{default: 1'b0};
  logic signed [31:0] kept_value [ENTRIES]   = '{default: '0};
  logic               kept_valid [ENTRIES]   = '{default: 1'b0};

  logic [47:0] key_pool [6];

  threshold_crossing_sample_filter_top #(
    .ENTRIES    (ENTRIES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // 4 ns clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // apply one transaction to the table copy and return its filter decision
  function automatic filter_out_t filter_predict(opcode_e op, logic [1:0] slot,
                                                 logic [47:0] key, logic key_en,
                                                 kind_e kind, logic thr_en,
                                                 logic signed [31:0] value);
    filter_out_t res;
    int hit;
    int t;
    int gi;
    int li;
    int si;
    logic [1:0] s;
    logic signed [32:0] delta;
    logic trig;
    logic drop_set;
    res = '0;
    res.reason = REASON_ACK;
    case (op)
      OP_WRITE_KEY: begin
        if (key_en) begin
          if (rule_key[slot] != key) begin
            seen_valid[slot] = 1'b0;
            kept_valid[slot] = 1'b0;
          end
          rule_key[slot]  = key;
          rule_used[slot] = 1'b1;
        end else begin
          rule_used[slot] = 1'b0;
        end
      end
      OP_WRITE_THR: begin
        if (kind != KIND_NONE) begin
          t = int'(slot) * 3 + int'(kind);
          if (thr_en) begin
            level[t]    = value;
            level_on[t] = 1'b1;
          end else begin
            level_on[t]      = 1'b0;
            seen_valid[slot] = 1'b0;
            kept_valid[slot] = 1'b0;
          end
        end
      end
      OP_SAMPLE: begin
        hit = -1;
        // scan from the top so the lowest matching slot is left in hit
        for (int i = ENTRIES - 1; i >= 0; i--) begin
          if (rule_used[i] && rule_key[i] == key) hit = i;
        end
        if (hit < 0) begin
          res.reason = REASON_NO_ENTRY;
        end else begin
          s  = hit[1:0];
          gi = hit * 3 + int'(KIND_GT);
          li = hit * 3 + int'(KIND_LT);
          si = hit * 3 + int'(KIND_ST);
          res.matched = 1'b1;
          res.slot    = s;
          if (!level_on[gi] && !level_on[li] && !level_on[si]) begin
            res.keep   = 1'b1;
            res.reason = REASON_NO_THR;
          end else begin
            trig       = 1'b0;
            drop_set   = 1'b0;
            res.reason = REASON_NONE;
            // rising above gt
            if (level_on[gi] && value > level[gi]) begin
              if (!seen_valid[s] || seen_value[s] <= level[gi]) begin
                trig       = 1'b1;
                res.reason = REASON_GT_CROSS;
              end else begin
                res.reason = REASON_ABOVE;
                drop_set   = 1'b1;
              end
            end
            // falling below lt
            if (!trig && level_on[li] && value < level[li]) begin
              if (!seen_valid[s] || seen_value[s] >= level[li]) begin
                trig       = 1'b1;
                res.reason = REASON_LT_CROSS;
              end else if (!drop_set) begin
                res.reason = REASON_BELOW;
                drop_set   = 1'b1;
              end
            end
            // step from the last kept value, one extra bit so it never wraps
            if (!trig && level_on[si]) begin
              if (!kept_valid[s]) begin
                trig       = 1'b1;
                res.reason = REASON_ST_FIRST;
              end else begin
                delta = 33'(value) - 33'(kept_value[s]);
                if (delta < 0) delta = -delta;
                if (delta >= 33'(level[si])) begin
                  trig       = 1'b1;
                  res.reason = REASON_STEP;
                end else if (!drop_set) begin
                  res.reason = REASON_STEP_SMALL;
                  drop_set   = 1'b1;
                end
              end
            end
            seen_value[s] = value;
            seen_valid[s] = 1'b1;
            if (trig) begin
              kept_value[s] = value;
              kept_valid[s] = 1'b1;
            end
            res.keep = trig;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // drive one transaction, wait for its handshake, queue its prediction
  task automatic push_command(opcode_e op, logic [1:0] slot, logic [47:0] key,
                              logic key_en, kind_e kind, logic thr_en,
                              logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= {2'b00, value, thr_en, kind, key_en,
                key[15:0], key[31:16], key[47:32], slot};
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_results.push_back(filter_predict(op, slot, key, key_en, kind, thr_en, value));
    sent_count++;
  endtask

  task automatic write_key(logic [1:0] slot, logic [47:0] key, logic en);
    push_command(OP_WRITE_KEY, slot, key, en, KIND_GT, 1'b0, '0);
  endtask

  task automatic write_thr(logic [1:0] slot, kind_e kind, logic en, logic [31:0] value);
    push_command(OP_WRITE_THR, slot, '0, 1'b0, kind, en, value);
  endtask

  task automatic send_sample(logic [47:0] key, logic [31:0] value);
    push_command(OP_SAMPLE, 2'd0, key, 1'b0, KIND_GT, 1'b0, value);
  endtask

  task automatic check_field(string fname, logic [3:0] exp_val, logic [3:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname,
               exp_val, got_val);
      fail_count++;
    end
  endtask

  // result side: compare each transaction with the oldest prediction
  always @(posedge clk_i) begin : result_check
    filter_out_t got_res;
    filter_out_t exp_res;
    if (m_axis_tvalid_o && m_ready) begin
      got_res = filter_out_t'(m_axis_tdata_o);
      if (expected_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %h", $time,
                 m_axis_tdata_o);
        fail_count++;
      end else begin
        exp_res = expected_results.pop_front();
        check_field("keep", 4'(exp_res.keep), 4'(got_res.keep));
        check_field("reason", 4'(exp_res.reason), 4'(got_res.reason));
        check_field("matched", 4'(exp_res.matched), 4'(got_res.matched));
        check_field("matched_slot", 4'(exp_res.slot), 4'(got_res.slot));
        checked_count++;
        if (exp_res.keep) kept_count++;
      end
    end
    m_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // samples before any key is written, and the unused opcode
  task automatic test_empty_table();
    send_sample(48'h0, 32'h0);
    push_command(OP_NOP, 2'd3, '1, 1'b1, KIND_NONE, 1'b1, 32'hFFFF_FFFF);
  endtask

  // duplicate keys, lowest slot wins, emptying a slot
  task automatic test_key_table();
    write_key(2'd0, 48'h1234_5678_9ABC, 1'b1);
    write_key(2'd2, 48'h1234_5678_9ABC, 1'b1);
    send_sample(48'h1234_5678_9ABC, 32'h0);
    write_key(2'd0, 48'h1234_5678_9ABC, 1'b0);
    send_sample(48'h1234_5678_9ABC, 32'h0);
    write_key(2'd3, 48'hFFFF_FFFF_FFFF, 1'b1);
    send_sample(48'hFFFF_FFFF_FFFF, 32'h8000_0000);
  endtask

  // gt/lt crossings, staying outside, ignored kind, value extremes
  task automatic test_crossings();
    write_thr(2'd3, KIND_GT, 1'b1, 32'h0);
    write_thr(2'd3, KIND_LT, 1'b1, -32'sh10000);
    write_thr(2'd3, KIND_NONE, 1'b1, 32'h7FFF_FFFF);
    send_sample(48'hFFFF_FFFF_FFFF, 32'h7FFF_FFFF);
    send_sample(48'hFFFF_FFFF_FFFF, 32'h0005_0000);
    send_sample(48'hFFFF_FFFF_FFFF, 32'h8000_0000);
    send_sample(48'hFFFF_FFFF_FFFF, -32'sh20000);
    send_sample(48'hFFFF_FFFF_FFFF, 32'h0);
  endtask

  // first sample, small and large steps, clearing st, negative st
  task automatic test_step_change();
    write_thr(2'd2, KIND_ST, 1'b1, 32'h0001_0000);
    send_sample(48'h1234_5678_9ABC, 32'h0);
    send_sample(48'h1234_5678_9ABC, 32'h0000_8000);
    send_sample(48'h1234_5678_9ABC, -32'sh10000);
    write_thr(2'd2, KIND_ST, 1'b0, 32'h0);
    write_thr(2'd2, KIND_ST, 1'b1, 32'hFFFF_FFFF);
    send_sample(48'h1234_5678_9ABC, 32'h0003_0000);
    send_sample(48'h1234_5678_9ABC, 32'h0003_0000);
  endtask

  // random mix on a small key pool so most samples hit a populated slot
  task automatic test_random_traffic(int count);
    int sel;
    int mode;
    opcode_e op;
    logic [47:0] key;
    logic [31:0] value;
    kind_e kind;
    for (int n = 0; n < count; n++) begin
      sel  = $urandom_range(99);
      mode = $urandom_range(9);
      key  = key_pool[$urandom_range(5)];
      kind = ($urandom_range(9) == 0) ? KIND_NONE : kind_e'($urandom_range(2));
      if (sel < 58) op = OP_SAMPLE;
      else if (sel < 72) op = OP_WRITE_KEY;
      else if (sel < 95) op = OP_WRITE_THR;
      else op = OP_NOP;
      // mostly small values near the thresholds, some full-range
      if (mode < 2) value = $urandom;
      else if (op == OP_WRITE_THR && kind == KIND_ST) value = $urandom_range(8) * 32'h4000;
      else value = (int'($urandom_range(16)) - 8) * 32'sh4000;
      // a few unknown keys: samples miss, key writes refresh the pool
      if (sel < 5 || (op == OP_WRITE_KEY && mode == 9)) begin
        key = 48'({$urandom, $urandom});
        if (op == OP_WRITE_KEY) key_pool[$urandom_range(5, 2)] = key;
      end
      push_command(op, 2'($urandom_range(3)), key, $urandom_range(99) < 85, kind,
                   $urandom_range(99) < 80, value);
    end
  endtask

  initial begin
    key_pool[0] = 48'h0;
    key_pool[1] = '1;
    for (int i = 2; i < 6; i++) key_pool[i] = 48'({$urandom, $urandom});
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 11;
    recv_idle_pct = 54;
    test_empty_table();
    test_key_table();
    test_crossings();
    test_step_change();
    test_random_traffic(200);
    send_idle_pct = 54;
    recv_idle_pct = 11;
    test_random_traffic(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(200);
    s_valid <= 1'b0;

    // drain the pipeline
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (ENTRIES + 8) @(posedge clk_i);

    $display("Run covered %0d transactions over three stall profiles", sent_count);
    $display("%0d results checked, %0d samples kept", checked_count, kept_count);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("Timeout after %0t ns", $time);
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/tcsf_pkg.sv
rtl/core/tcsf_cell.sv
rtl/core/threshold_crossing_sample_filter_top.sv
tb/tb_threshold_crossing_sample_filter_top.sv
